// ===== sv/qalu_pkg.sv =====
package qalu_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 24;
    localparam int FIELD_BITS    = 32;
    localparam int MAG_BITS      = 31;
    localparam int ACT_BITS      = 3;
    localparam int IN_DATA_BITS  = 296;
    localparam int OUT_DATA_BITS = 160;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = 2;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_PRODUCT   = 3'd0,
        ACT_CONJUGATE = 3'd1,
        ACT_SCALE     = 3'd2,
        ACT_DIVIDE    = 3'd3,
        ACT_NORM      = 3'd4,
        ACT_NORMALIZE = 3'd5,
        ACT_INVERSE   = 3'd6,
        ACT_NONE      = 3'd7
    } action_t;

    // Decoded request as handed from the front end to the back end.
    typedef struct packed {
        action_t                      action;
        logic                         use_div;
        logic                         div_src_scalar;
        logic signed [FIELD_BITS-1:0] p_real;
        logic signed [FIELD_BITS-1:0] p_i;
        logic signed [FIELD_BITS-1:0] p_j;
        logic signed [FIELD_BITS-1:0] p_k;
        logic signed [FIELD_BITS-1:0] q_real;
        logic signed [FIELD_BITS-1:0] q_i;
        logic signed [FIELD_BITS-1:0] q_j;
        logic signed [FIELD_BITS-1:0] q_k;
        logic signed [FIELD_BITS-1:0] scalar;
    } req_t;

endpackage

// ===== sv/qalu_front.sv =====
module qalu_front
    import qalu_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    output logic                     q_valid,
    input  logic                     q_ready,
    output req_t                     q_req
);

    req_t                 req_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;
    req_t                 dec;
    logic                 push, pop;

    always_comb begin
        dec.action         = action_t'(s_tdata[ACT_BITS-1:0]);
        dec.p_real         = s_tdata[8   +: FIELD_BITS];
        dec.p_i            = s_tdata[40  +: FIELD_BITS];
        dec.p_j            = s_tdata[72  +: FIELD_BITS];
        dec.p_k            = s_tdata[104 +: FIELD_BITS];
        dec.q_real         = s_tdata[136 +: FIELD_BITS];
        dec.q_i            = s_tdata[168 +: FIELD_BITS];
        dec.q_j            = s_tdata[200 +: FIELD_BITS];
        dec.q_k            = s_tdata[232 +: FIELD_BITS];
        dec.scalar         = s_tdata[264 +: FIELD_BITS];
        dec.use_div        = 1'b0;
        dec.div_src_scalar = 1'b0;
        unique case (dec.action) inside
            ACT_DIVIDE: begin
                dec.use_div        = 1'b1;
                dec.div_src_scalar = 1'b1;
            end
            ACT_NORMALIZE, ACT_INVERSE: dec.use_div = 1'b1;
            default: ;
        endcase
    end

    assign s_tready = (count_reg != QUEUE_DEPTH[QPTR_BITS:0]);
    assign q_valid  = (count_reg != '0);
    assign q_req    = req_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            req_reg[wr_ptr_reg] <= dec;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + {{QPTR_BITS{1'b0}}, push} - {{QPTR_BITS{1'b0}}, pop};
        end
    end

endmodule

// ===== sv/qalu_back.sv =====
module qalu_back
    import qalu_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  req_t                     q_req,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    output logic                     m_tuser
);

    localparam int W    = WORD_BITS;
    localparam int PW   = 2 * W + 2;
    localparam int SW   = 2 * W + 3;
    localparam int RB   = W + 1;
    localparam int NB   = W + FRAC_BITS + 1;
    localparam int DW   = 2 * W - FRAC_BITS + 2;
    localparam int QB   = NB;
    localparam int DEPTH = 2 + RB + QB;
    localparam logic signed [SW-1:0] WMAX = SW'((65'sd1 <<< (W - 1)) - 1);
    localparam logic signed [SW-1:0] WMIN = -WMAX - 1;

    typedef logic signed [SW-1:0] sq_t;

    // One stage of pipeline per step; wide items travel in arrays indexed by stage.
    logic              v_reg   [DEPTH];
    action_t           act_reg [DEPTH];
    logic signed [W-1:0] p_reg [DEPTH][4];
    logic signed [W-1:0] q_reg [DEPTH][4];
    logic signed [W-1:0] s_reg [DEPTH];
    logic signed [PW-1:0] prod_reg [DEPTH][4][4];
    logic [2*W+1:0]    nsum_reg [DEPTH];
    logic [W:0]        root_reg [DEPTH];
    logic signed [DW-1:0] den_reg [DEPTH];
    logic              dz_reg   [DEPTH];
    logic [NB-1:0]     num_reg  [DEPTH][4];
    logic [NB-1:0]     nrem_reg [DEPTH][4];
    logic [QB-1:0]     quo_reg  [DEPTH][4];
    logic              neg_reg  [DEPTH][4];

    logic out_valid_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg;
    logic out_dz_reg;
    logic adv;

    assign adv     = !out_valid_reg || m_tready;
    assign q_ready = adv;

    function automatic logic signed [W-1:0] sat_w(input sq_t x);
        if (x > WMAX) return WMAX[W-1:0];
        if (x < WMIN) return WMIN[W-1:0];
        return x[W-1:0];
    endfunction

    function automatic logic signed [FIELD_BITS-1:0] ext(input logic signed [W-1:0] x);
        return FIELD_BITS'(x);
    endfunction

    function automatic logic signed [W-1:0] sx_in(input logic [FIELD_BITS-1:0] x);
        return x[W-1:0];
    endfunction

    localparam int ST_SQRT = 2;
    localparam int ST_DIV  = 2 + RB;
    localparam int ST_FIN  = 2 + RB + QB;

    genvar g;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) v_reg[i] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= q_valid;
            for (int i = 1; i < DEPTH; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    // stage 0: capture and multiply every p*q pair, or each p by the scalar for scale
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic signed [W-1:0] pv [4];
            logic signed [W-1:0] qv [4];
            logic signed [W-1:0] sv;
            pv[0] = sx_in(q_req.p_real); pv[1] = sx_in(q_req.p_i);
            pv[2] = sx_in(q_req.p_j);    pv[3] = sx_in(q_req.p_k);
            qv[0] = sx_in(q_req.q_real); qv[1] = sx_in(q_req.q_i);
            qv[2] = sx_in(q_req.q_j);    qv[3] = sx_in(q_req.q_k);
            sv = sx_in(q_req.scalar);
            act_reg[0] <= q_req.action;
            s_reg[0] <= sv;
            for (int a = 0; a < 4; a++) begin
                p_reg[0][a] <= pv[a];
                q_reg[0][a] <= qv[a];
                for (int b = 0; b < 4; b++)
                    prod_reg[0][a][b] <= PW'(pv[a] * (q_req.action == ACT_SCALE ? sv : qv[b]));
            end
        end
    end

    // stage 1: squared norm of p
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic [2*W+1:0] acc;
            acc = '0;
            for (int a = 0; a < 4; a++)
                acc = acc + (2*W+2)'(p_reg[0][a] * p_reg[0][a]);
            act_reg[1] <= act_reg[0];
            s_reg[1] <= s_reg[0];
            for (int a = 0; a < 4; a++) begin
                p_reg[1][a] <= p_reg[0][a];
                q_reg[1][a] <= q_reg[0][a];
                for (int b = 0; b < 4; b++) prod_reg[1][a][b] <= prod_reg[0][a][b];
            end
            nsum_reg[1] <= acc;
            root_reg[1] <= '0;
        end
    end

    // square root: one result bit per stage
    generate
        for (g = ST_SQRT; g < ST_DIV; g++) begin : g_sqrt
            localparam int BIT = ST_DIV - 1 - g;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    logic [W:0] c;
                    logic [2*W+3:0] cc;
                    c  = root_reg[g-1] | ((W+1)'(1) << BIT);
                    cc = (2*W+4)'(c) * (2*W+4)'(c);
                    root_reg[g] <= (cc <= (2*W+4)'(nsum_reg[g-1])) ? c : root_reg[g-1];
                    nsum_reg[g] <= nsum_reg[g-1];
                    act_reg[g] <= act_reg[g-1];
                    s_reg[g] <= s_reg[g-1];
                    for (int a = 0; a < 4; a++) begin
                        p_reg[g][a] <= p_reg[g-1][a];
                        q_reg[g][a] <= q_reg[g-1][a];
                        for (int b = 0; b < 4; b++) prod_reg[g][a][b] <= prod_reg[g-1][a][b];
                    end
                    if (g == ST_DIV - 1) begin
                        logic signed [DW-1:0] d;
                        logic [W:0] rt;
                        rt = (cc <= (2*W+4)'(nsum_reg[g-1])) ? c : root_reg[g-1];
                        unique case (act_reg[g-1])
                            ACT_DIVIDE:    d = DW'(s_reg[g-1]);
                            ACT_NORMALIZE: d = DW'({1'b0, rt});
                            default:       d = DW'({1'b0, nsum_reg[g-1] >> FRAC_BITS});
                        endcase
                        den_reg[g] <= d;
                        dz_reg[g]  <= (d == '0) && (act_reg[g-1] == ACT_DIVIDE ||
                                      act_reg[g-1] == ACT_NORMALIZE ||
                                      act_reg[g-1] == ACT_INVERSE);
                        for (int a = 0; a < 4; a++) begin
                            logic signed [W:0] n;
                            n = (act_reg[g-1] == ACT_INVERSE && a != 0) ?
                                -(W+1)'(p_reg[g-1][a]) : (W+1)'(p_reg[g-1][a]);
                            neg_reg[g][a]  <= n[W] ^ d[DW-1];
                            num_reg[g][a]  <= NB'(n[W] ? -n : n) << FRAC_BITS;
                            nrem_reg[g][a] <= '0;
                            quo_reg[g][a]  <= '0;
                        end
                    end
                end
            end
        end

        // restoring divider: one quotient bit per stage, four lanes
        for (g = ST_DIV; g < ST_FIN; g++) begin : g_div
            localparam int BIT = ST_FIN - 1 - g;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    logic [DW-1:0] dm;
                    dm = den_reg[g-1][DW-1] ? -den_reg[g-1] : den_reg[g-1];
                    for (int a = 0; a < 4; a++) begin
                        logic [NB+DW-1:0] r;
                        r = {(NB+DW-1)'(nrem_reg[g-1][a]), num_reg[g-1][a][BIT]};
                        if (r >= (NB+DW)'(dm) && dm != '0) begin
                            nrem_reg[g][a] <= NB'(r - (NB+DW)'(dm));
                            quo_reg[g][a]  <= quo_reg[g-1][a] | (QB'(1) << BIT);
                        end else begin
                            nrem_reg[g][a] <= NB'(r);
                            quo_reg[g][a]  <= quo_reg[g-1][a];
                        end
                        num_reg[g][a] <= num_reg[g-1][a];
                        neg_reg[g][a] <= neg_reg[g-1][a];
                        p_reg[g][a] <= p_reg[g-1][a];
                        q_reg[g][a] <= q_reg[g-1][a];
                        for (int b = 0; b < 4; b++) prod_reg[g][a][b] <= prod_reg[g-1][a][b];
                    end
                    den_reg[g] <= den_reg[g-1];
                    dz_reg[g] <= dz_reg[g-1];
                    root_reg[g] <= root_reg[g-1];
                    act_reg[g] <= act_reg[g-1];
                end
            end
        end
    endgenerate

    // final stage: Hamilton sums, saturation, select
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= v_reg[ST_FIN-1];
        end
        if (adv) begin
            sq_t t [4];
            logic signed [W-1:0] r [4];
            logic [W:0] rt;
            logic [MAG_BITS-1:0] mg;
            rt = root_reg[ST_FIN-1];
            t[0] = sq_t'(prod_reg[ST_FIN-1][0][0]) - sq_t'(prod_reg[ST_FIN-1][1][1])
                 - sq_t'(prod_reg[ST_FIN-1][2][2]) - sq_t'(prod_reg[ST_FIN-1][3][3]);
            t[1] = sq_t'(prod_reg[ST_FIN-1][0][1]) + sq_t'(prod_reg[ST_FIN-1][1][0])
                 + sq_t'(prod_reg[ST_FIN-1][2][3]) - sq_t'(prod_reg[ST_FIN-1][3][2]);
            t[2] = sq_t'(prod_reg[ST_FIN-1][0][2]) - sq_t'(prod_reg[ST_FIN-1][1][3])
                 + sq_t'(prod_reg[ST_FIN-1][2][0]) + sq_t'(prod_reg[ST_FIN-1][3][1]);
            t[3] = sq_t'(prod_reg[ST_FIN-1][0][3]) + sq_t'(prod_reg[ST_FIN-1][1][2])
                 - sq_t'(prod_reg[ST_FIN-1][2][1]) + sq_t'(prod_reg[ST_FIN-1][3][0]);
            for (int a = 0; a < 4; a++) r[a] = '0;
            case (act_reg[ST_FIN-1]) inside
                ACT_PRODUCT:
                    for (int a = 0; a < 4; a++) r[a] = sat_w(t[a] >>> FRAC_BITS);
                ACT_CONJUGATE: begin
                    r[0] = p_reg[ST_FIN-1][0];
                    for (int a = 1; a < 4; a++) r[a] = sat_w(-sq_t'(p_reg[ST_FIN-1][a]));
                end
                ACT_SCALE:
                    for (int a = 0; a < 4; a++)
                        r[a] = sat_w(sq_t'(prod_reg[ST_FIN-1][a][0]) >>> FRAC_BITS);
                ACT_NORM: r[0] = sat_w(sq_t'({1'b0, rt}));
                ACT_DIVIDE, ACT_NORMALIZE, ACT_INVERSE:
                    if (!dz_reg[ST_FIN-1])
                        for (int a = 0; a < 4; a++)
                            r[a] = sat_w(neg_reg[ST_FIN-1][a] ?
                                -sq_t'({1'b0, quo_reg[ST_FIN-1][a]}) :
                                 sq_t'({1'b0, quo_reg[ST_FIN-1][a]}));
                default: ;
            endcase
            mg = (rt > (W+1)'(WMAX)) ? MAG_BITS'(WMAX) : MAG_BITS'(rt);
            out_data_reg <= {1'b0, mg, ext(r[3]), ext(r[2]), ext(r[1]), ext(r[0])};
            out_dz_reg <= dz_reg[ST_FIN-1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_dz_reg;

endmodule

// ===== sv/quaternion_alu.sv =====
// Quaternion arithmetic unit, signed fixed point (Q8.24 by default). One request
// per cycle is accepted while the request queue is not full; the pipeline depth is
// set by the bit-per-stage square root and the bit-per-stage restoring divider.
// A four-entry request queue sits in front of the pipeline; the pipeline stalls
// as a whole when the output is held. div_zero travels on m_tuser.
module quaternion_alu
    import qalu_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // action[2:0], 5 zero bits, p_real, p_i, p_j, p_k, q_real, q_i, q_j, q_k, scalar
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // r_real, r_i, r_j, r_k, magnitude[30:0], 1 zero bit
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    // div_zero
    output logic                     m_tuser
);

    logic q_valid, q_ready;
    req_t q_req;

    qalu_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .q_valid, .q_ready, .q_req
    );

    qalu_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_req,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    a_dz_only_div: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[127:0] == '0);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");

endmodule

// ===== bench/tb_quaternion_alu.sv =====
`timescale 1ns / 1ps

module tb_quaternion_alu;
    import qalu_pkg::*;

    localparam int  LAT        = 32 + 24 + 32 + 5;
    localparam int  CYCLE_CAP  = 400000;
    localparam int  RAND_ITEMS = 450;
    localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE   = 32'sh0100_0000;

    typedef struct packed {
        logic signed [31:0] r_real;
        logic signed [31:0] r_i;
        logic signed [31:0] r_j;
        logic signed [31:0] r_k;
        logic [30:0]        magnitude;
        logic               div_zero;
    } qres_t;

    typedef struct {
        action_t            act;
        logic signed [31:0] p [4];
        logic signed [31:0] q [4];
        logic signed [31:0] s;
        bit                 typed;
        qres_t              res;
    } qreq_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tuser;

    qres_t  pending_res [$];
    qres_t  next_res;
    qreq_t  directed [$];
    bit     s_taken;
    bit     quiet;
    int     cycles;
    int     errors;
    int     n_checked;
    int     act_seen [8];

    quaternion_alu i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic logic signed [31:0] clamp(input logic signed [127:0] x);
        if (x > 128'(W_MAX)) return W_MAX;
        if (x < 128'(W_MIN)) return W_MIN;
        return x[31:0];
    endfunction

    // floor of the full-precision sum, shifted down to Q8.24
    function automatic logic signed [31:0] fx_sum(input logic signed [127:0] a,
                                                  input logic signed [127:0] b,
                                                  input logic signed [127:0] c,
                                                  input logic signed [127:0] d);
        logic signed [127:0] t;
        t = (a + b + c + d) >>> 24;
        return clamp(t);
    endfunction

    function automatic logic signed [31:0] fx_div(input logic signed [63:0] num,
                                                  input logic signed [63:0] den);
        logic signed [127:0] t;
        t = 128'((num <<< 24) / den);
        return clamp(t);
    endfunction

    function automatic qres_t quat_eval(input qreq_t rq);
        qres_t               o;
        logic signed [127:0] a [4];
        logic signed [127:0] b [4];
        logic [67:0]         sumsq;
        logic [67:0]         root;
        logic [67:0]         trial;
        logic signed [63:0]  nsq;
        for (int n = 0; n < 4; n++) begin
            a[n] = 128'(rq.p[n]);
            b[n] = 128'(rq.q[n]);
        end
        o = '0;
        sumsq = '0;
        for (int n = 0; n < 4; n++) sumsq += 68'(a[n] * a[n]);
        root = '0;
        for (int bt = 33; bt >= 0; bt--) begin
            trial = root | (68'd1 << bt);
            if (trial * trial <= sumsq) root = trial;
        end
        o.magnitude = (root > 68'(W_MAX)) ? 31'(W_MAX) : root[30:0];
        case (rq.act)
            ACT_PRODUCT: begin
                o.r_real = fx_sum(a[0]*b[0], -(a[1]*b[1]), -(a[2]*b[2]), -(a[3]*b[3]));
                o.r_i    = fx_sum(a[0]*b[1], a[1]*b[0], a[2]*b[3], -(a[3]*b[2]));
                o.r_j    = fx_sum(a[0]*b[2], -(a[1]*b[3]), a[2]*b[0], a[3]*b[1]);
                o.r_k    = fx_sum(a[0]*b[3], a[1]*b[2], -(a[2]*b[1]), a[3]*b[0]);
            end
            ACT_CONJUGATE: begin
                o.r_real = rq.p[0];
                o.r_i    = clamp(-a[1]);
                o.r_j    = clamp(-a[2]);
                o.r_k    = clamp(-a[3]);
            end
            ACT_SCALE: begin
                o.r_real = fx_sum(a[0] * 128'(rq.s), 0, 0, 0);
                o.r_i    = fx_sum(a[1] * 128'(rq.s), 0, 0, 0);
                o.r_j    = fx_sum(a[2] * 128'(rq.s), 0, 0, 0);
                o.r_k    = fx_sum(a[3] * 128'(rq.s), 0, 0, 0);
            end
            ACT_DIVIDE: begin
                if (rq.s == 0) o.div_zero = 1'b1;
                else begin
                    o.r_real = fx_div(64'(rq.p[0]), 64'(rq.s));
                    o.r_i    = fx_div(64'(rq.p[1]), 64'(rq.s));
                    o.r_j    = fx_div(64'(rq.p[2]), 64'(rq.s));
                    o.r_k    = fx_div(64'(rq.p[3]), 64'(rq.s));
                end
            end
            ACT_NORM: o.r_real = clamp(128'(root));
            ACT_NORMALIZE: begin
                if (root == 0) o.div_zero = 1'b1;
                else begin
                    o.r_real = fx_div(64'(rq.p[0]), 64'(root));
                    o.r_i    = fx_div(64'(rq.p[1]), 64'(root));
                    o.r_j    = fx_div(64'(rq.p[2]), 64'(root));
                    o.r_k    = fx_div(64'(rq.p[3]), 64'(root));
                end
            end
            ACT_INVERSE: begin
                nsq = 64'(sumsq >> 24);
                if (nsq == 0) o.div_zero = 1'b1;
                else begin
                    o.r_real = fx_div(64'(rq.p[0]), nsq);
                    o.r_i    = fx_div(-64'(rq.p[1]), nsq);
                    o.r_j    = fx_div(-64'(rq.p[2]), nsq);
                    o.r_k    = fx_div(-64'(rq.p[3]), nsq);
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string fld, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch at result %0d: %s got %h want %h", n_checked, fld, got, want);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        s_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) pending_res.push_back(next_res);
        if (aresetn && m_tvalid && m_tready) begin
            qres_t want;
            if (pending_res.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
            end else begin
                want = pending_res.pop_front();
                if (m_tdata[31:0] !== want.r_real)
                    report_mismatch("r_real", m_tdata[31:0], want.r_real);
                if (m_tdata[63:32] !== want.r_i)
                    report_mismatch("r_i", m_tdata[63:32], want.r_i);
                if (m_tdata[95:64] !== want.r_j)
                    report_mismatch("r_j", m_tdata[95:64], want.r_j);
                if (m_tdata[127:96] !== want.r_k)
                    report_mismatch("r_k", m_tdata[127:96], want.r_k);
                if (m_tdata[158:128] !== want.magnitude)
                    report_mismatch("magnitude", m_tdata[158:128], want.magnitude);
                if (m_tuser !== want.div_zero)
                    report_mismatch("div_zero", m_tuser, want.div_zero);
            end
            n_checked++;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= quiet || ($urandom_range(99) >= 17);
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // one request: optional idle gap, then hold valid until taken
    task automatic send_req(input qreq_t rq);
        if (!quiet && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        next_res = rq.typed ? rq.res : quat_eval(rq);
        s_tdata  <= {rq.s, rq.q[3], rq.q[2], rq.q[1], rq.q[0],
                     rq.p[3], rq.p[2], rq.p[1], rq.p[0], 5'b0, rq.act};
        s_tvalid <= 1'b1;
        act_seen[rq.act]++;
        do begin
            @(posedge aclk);
            #1;
        end while (!s_taken);
        @(negedge aclk);
    endtask

    task automatic add_row(input action_t act,
                           input logic signed [31:0] p0, p1, p2, p3,
                           input logic signed [31:0] q0, q1, q2, q3,
                           input logic signed [31:0] s,
                           input bit typed, input qres_t res);
        qreq_t rq;
        rq.act = act;
        rq.p = '{p0, p1, p2, p3};
        rq.q = '{q0, q1, q2, q3};
        rq.s = s;
        rq.typed = typed;
        rq.res = res;
        directed.push_back(rq);
    endtask

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(4))
            0, 1: return $urandom;
            2:    return $signed($urandom) >>> $urandom_range(4, 12);
            3:    return $signed($urandom_range(0, 511)) - 256;
            default: begin
                case ($urandom_range(4))
                    0: return W_MAX;
                    1: return W_MIN;
                    2: return 0;
                    3: return ONE;
                    default: return -ONE;
                endcase
            end
        endcase
    endfunction

    initial begin
        qreq_t rq;
        qres_t nil;
        nil = '0;
        cycles = 0;
        errors = 0;
        n_checked = 0;
        quiet = 1'b0;

        // rows with results read straight off the spec
        add_row(ACT_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, nil);
        add_row(ACT_CONJUGATE, 0, W_MIN, 0, 0, 0, 0, 0, 0, 0, 1,
                '{0, W_MAX, 0, 0, 31'h7FFF_FFFF, 1'b0});
        add_row(ACT_DIVIDE, 0, 0, 0, 0, 5, 5, 5, 5, 0, 1, '{0, 0, 0, 0, 0, 1'b1});
        add_row(ACT_NORMALIZE, 0, 0, 0, 0, ONE, ONE, ONE, ONE, ONE, 1,
                '{0, 0, 0, 0, 0, 1'b1});
        add_row(ACT_INVERSE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 1, 1'b1});
        add_row(ACT_NORM, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{ONE, 0, 0, 0, 31'(ONE), 1'b0});
        add_row(ACT_NONE, 0, 0, 0, 0, ONE, ONE, ONE, ONE, ONE, 1, nil);
        // predicted rows
        add_row(ACT_PRODUCT, W_MAX, W_MIN, W_MAX, W_MIN, W_MIN, W_MAX, W_MIN, W_MAX, 0, 0, nil);
        add_row(ACT_PRODUCT, ONE, 2*ONE, -ONE, 3, -ONE, ONE, ONE/2, 7, 0, 0, nil);
        add_row(ACT_CONJUGATE, W_MIN, W_MAX, W_MIN, -1, 0, 0, 0, 0, 0, 0, nil);
        add_row(ACT_SCALE, W_MAX, W_MIN, -1, 1, 0, 0, 0, 0, W_MIN, 0, nil);
        add_row(ACT_SCALE, ONE, -ONE, 3, -3, 0, 0, 0, 0, ONE/4, 0, nil);
        add_row(ACT_DIVIDE, W_MIN, W_MAX, 1, -1, 0, 0, 0, 0, 1, 0, nil);
        add_row(ACT_DIVIDE, ONE, -ONE, 7, 100, 0, 0, 0, 0, -3*ONE, 0, nil);
        add_row(ACT_NORM, W_MIN, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0, 0, 0, nil);
        add_row(ACT_NORMALIZE, W_MIN, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0, 0, 0, nil);
        add_row(ACT_NORMALIZE, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0, nil);
        add_row(ACT_INVERSE, W_MIN, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0, 0, 0, nil);
        add_row(ACT_INVERSE, 4096, 0, 0, 0, 0, 0, 0, 0, 0, 0, nil);
        add_row(ACT_INVERSE, ONE, ONE, -ONE, 0, 0, 0, 0, 0, 0, 0, nil);
        add_row(ACT_NONE, W_MIN, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0, 0, 0, nil);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) send_req(directed[i]);

        // hold off until the pipeline has drained
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_res.size() != 0) @(negedge aclk);

        for (int it = 0; it < RAND_ITEMS; it++) begin
            quiet = (it >= 200 && it < 300);
            rq.act = action_t'($urandom_range(7));
            for (int n = 0; n < 4; n++) begin
                rq.p[n] = pick_word();
                rq.q[n] = pick_word();
            end
            rq.s = ($urandom_range(9) == 0) ? 32'sd0 : pick_word();
            rq.typed = 1'b0;
            rq.res = nil;
            send_req(rq);
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_res.size() != 0) @(negedge aclk);
        repeat (LAT + 20) @(negedge aclk);

        $display("covered %0d results over all eight action codes (%0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d)",
                 n_checked, act_seen[0], act_seen[1], act_seen[2], act_seen[3],
                 act_seen[4], act_seen[5], act_seen[6], act_seen[7]);
        $display("directed extremes, zero divisors and saturation, then random traffic with stalls");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
